/* sv/binomial_3x3_lowpass_core_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the binomial 3x3 lowpass core
// Clocked property wrappers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef BINOMIAL_3X3_LOWPASS_CORE_MACROS_SVH
`define BINOMIAL_3X3_LOWPASS_CORE_MACROS_SVH

// Property checked only while out of reset.
`define B3LP_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("%m: property failed");

// Property checked on every edge, reset included.
`define B3LP_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("%m: property failed");

`endif

/* sv/b3lp_pkg.sv */
// ----------------------------------------------------------------------------
// b3lp_pkg
// Shared types, register indexes and the 1-2-1 tap for the lowpass core.
// ----------------------------------------------------------------------------
package b3lp_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_DOWNSAMPLE   = 2'd2;

    localparam logic [12:0] RESET_WIDTH  = 13'd640;
    localparam logic [12:0] RESET_HEIGHT = 13'd480;

    // request kind
    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_FLUSH = 1'b1;

    // output queue
    localparam int OFIFO_DEPTH = 8;
    localparam int OFIFO_PTR_W = 3;
    localparam int OFIFO_CNT_W = 4;

    typedef struct packed {
        logic [7:0] pixel;
        logic       row_end;
        logic       frame_end;
    } result_t;

    // results produced by one request, first in r0
    typedef struct packed {
        logic [1:0] cnt;
        result_t    r0;
        result_t    r1;
    } push_t;

    // (a + 2b + c + 2) >> 2
    function automatic logic [7:0] tap121(input logic [7:0] a, input logic [7:0] b,
                                          input logic [7:0] c);
        logic [9:0] s;
        s = {2'b00, a} + {1'b0, b, 1'b0} + {2'b00, c} + 10'd2;
        return s[9:2];
    endfunction

endpackage

/* sv/b3lp_linebuf.sv */
// ----------------------------------------------------------------------------
// b3lp_linebuf
// Two line memories (row above, current row), one write and one read port
// each, registered read with write-to-read forwarding on the same entry.
// ----------------------------------------------------------------------------
module b3lp_linebuf #(
    parameter int DEPTH = 4096,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic          aclk,
    input  logic [AW-1:0] waddr,
    input  logic [AW-1:0] raddr,
    input  logic          we_cur,
    input  logic          we_above,
    input  logic [7:0]    din_cur,
    input  logic [7:0]    din_above,
    output logic [7:0]    rd_cur,
    output logic [7:0]    rd_above
);

    logic [7:0] cur_mem   [DEPTH];
    logic [7:0] above_mem [DEPTH];
    logic [7:0] rd_cur_reg;
    logic [7:0] rd_above_reg;

    always_ff @(posedge aclk) begin
        if (we_cur) begin
            cur_mem[waddr] <= din_cur;
        end
        if (we_cur && waddr == raddr) begin
            rd_cur_reg <= din_cur;
        end else begin
            rd_cur_reg <= cur_mem[raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (we_above) begin
            above_mem[waddr] <= din_above;
        end
        if (we_above && waddr == raddr) begin
            rd_above_reg <= din_above;
        end else begin
            rd_above_reg <= above_mem[raddr];
        end
    end

    assign rd_cur   = rd_cur_reg;
    assign rd_above = rd_above_reg;

endmodule

/* sv/b3lp_ofifo.sv */
// ----------------------------------------------------------------------------
// b3lp_ofifo
// Small result queue: up to two pushes and one pop per cycle.
// ----------------------------------------------------------------------------
module b3lp_ofifo (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  b3lp_pkg::push_t                    push,
    input  logic                               pop,
    output b3lp_pkg::result_t                  head,
    output logic [b3lp_pkg::OFIFO_CNT_W-1:0]   count
);
    import b3lp_pkg::*;

    result_t                fifo [OFIFO_DEPTH];
    logic [OFIFO_PTR_W-1:0] wr_reg, wr_next;
    logic [OFIFO_PTR_W-1:0] rd_reg, rd_next;
    logic [OFIFO_CNT_W-1:0] cnt_reg, cnt_next;
    logic [OFIFO_PTR_W-1:0] wr_plus1;

    assign wr_plus1 = wr_reg + OFIFO_PTR_W'(1);

    always_comb begin
        wr_next  = wr_reg + OFIFO_PTR_W'(push.cnt);
        rd_next  = rd_reg + OFIFO_PTR_W'(pop);
        cnt_next = cnt_reg + OFIFO_CNT_W'(push.cnt) - OFIFO_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.cnt != 2'd0) begin
            fifo[wr_reg] <= push.r0;
        end
        if (push.cnt == 2'd2) begin
            fifo[wr_plus1] <= push.r1;
        end
    end

    assign head  = fifo[rd_reg];
    assign count = cnt_reg;

endmodule

/* sv/binomial_3x3_lowpass_core.sv */
// ----------------------------------------------------------------------------
// binomial_3x3_lowpass_core
// Separable 1-2-1 binomial lowpass on an 8-bit raster stream, with edge
// replication and optional 2:1 decimation in both directions.
// ----------------------------------------------------------------------------
// Channel  | Dir | Handshake        | Payload
// s_       | in  | s_tvalid/tready  | tdata[7:0] pixel_in, tuser[0] mode
// m_       | out | m_tvalid/tready  | tdata[7:0] pixel_out, tlast row_end,
//          |     |                  | tuser[0] frame_end
// cfg_     | in  | cfg_valid/ready  | cfg_index register, cfg_data value
//
// One request per clock sustained while s_tready is high. The line memories are read
// ahead at the next column address, so a request finds its column ready.
// Results pass through the horizontal stage register and an 8-entry queue;
// s_tready drops when the queued results plus those in the horizontal stage
// leave fewer than two queue slots free.
// Synchronous active-low reset; line memories are not cleared (never read
// before written within a frame), no clearing pass.
// ----------------------------------------------------------------------------
module binomial_3x3_lowpass_core #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input pixels
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] pixel_in
    input  logic [0:0]  s_tuser,    // [0] mode (0 pixel, 1 flush)
    // filtered pixels
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [7:0] pixel_out
    output logic        m_tlast,    // row_end
    output logic [0:0]  m_tuser,    // [0] frame_end
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data
);
    import b3lp_pkg::*;

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int CMPW = (CW + 1 > 13) ? CW + 1 : 13;

    // ---------------- configuration ----------------
    logic [12:0] width_reg;
    logic [12:0] height_reg;
    logic        ds_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= RESET_WIDTH;
            height_reg <= RESET_HEIGHT;
            ds_reg     <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_FRAME_WIDTH:  width_reg  <= cfg_data;
                CFG_FRAME_HEIGHT: height_reg <= cfg_data;
                CFG_DOWNSAMPLE:   ds_reg     <= cfg_data[0];
                default: ;  // unmapped index: dropped
            endcase
        end
    end

    // zero sizes act as one
    logic [12:0] fw_eff;
    logic [12:0] fh_eff;
    assign fw_eff = (width_reg == 13'd0) ? 13'd1 : width_reg;
    assign fh_eff = (height_reg == 13'd0) ? 13'd1 : height_reg;

    // ---------------- position state ----------------
    logic [CW-1:0] col_reg, col_next;
    logic [12:0]   row_reg, row_next;    // input rows taken this frame
    logic [7:0]    prev1_reg, prev1_next; // vertical result, column - 1
    logic [7:0]    prev2_reg, prev2_next; // vertical result, column - 2

    // ---------------- line memories ----------------
    logic [CW-1:0] mem_raddr;
    logic          we_cur, we_above;
    logic [7:0]    rd_cur, rd_above;
    logic [7:0]    pix;

    // ---------------- request decode ----------------
    logic            acc;
    logic            flushing;
    logic            eff;        // request that changes state
    logic [CMPW-1:0] c1;
    logic            end_row;
    logic            row_kept;
    logic            last_row;
    logic [7:0]      above;
    logic [7:0]      vert;
    logic            emit1, emit2;

    assign acc      = s_tvalid && s_tready;
    assign flushing = row_reg >= fh_eff;
    // a flush before the last row is in does nothing
    assign eff      = acc && !(!flushing && s_tuser[0] == MODE_FLUSH);

    assign c1      = CMPW'(col_reg) + CMPW'(1);
    assign end_row = (c1 >= CMPW'(fw_eff)) || (c1 >= CMPW'(MAX_WIDTH));

    // during flush the current row is replicated as the row below
    assign pix   = flushing ? rd_cur : s_tdata;
    // first filtered row replicates its own top edge
    assign above = (row_reg == 13'd1) ? rd_cur : rd_above;
    assign vert  = tap121(above, rd_cur, pix);

    assign row_kept = !ds_reg || row_reg[0];
    assign last_row = ds_reg ? ({1'b0, row_reg} + 14'd1 >= {1'b0, fh_eff})
                             : (row_reg >= fh_eff);

    // emit1: result for column - 1; emit2: right-edge result at row end
    assign emit1 = (row_reg != 13'd0) && (col_reg != '0) && row_kept
                   && (!ds_reg || col_reg[0]);
    assign emit2 = (row_reg != 13'd0) && end_row && row_kept
                   && (!ds_reg || !col_reg[0]);

    // read one column ahead so the next request finds its data registered
    always_comb begin
        mem_raddr = col_reg;
        if (eff) begin
            mem_raddr = end_row ? '0 : c1[CW-1:0];
        end
    end

    assign we_cur   = eff;
    assign we_above = eff && (row_reg != 13'd0);

    b3lp_linebuf #(
        .DEPTH (MAX_WIDTH)
    ) u_linebuf (
        .aclk      (aclk),
        .waddr     (col_reg),
        .raddr     (mem_raddr),
        .we_cur    (we_cur),
        .we_above  (we_above),
        .din_cur   (pix),
        .din_above (rd_cur),
        .rd_cur    (rd_cur),
        .rd_above  (rd_above)
    );

    always_comb begin
        col_next   = col_reg;
        row_next   = row_reg;
        prev1_next = prev1_reg;
        prev2_next = prev2_reg;
        if (eff) begin
            if (end_row) begin
                col_next = '0;
                row_next = flushing ? 13'd0 : row_reg + 13'd1;
            end else begin
                col_next = c1[CW-1:0];
            end
            if (row_reg != 13'd0) begin
                prev2_next = prev1_reg;
                prev1_next = vert;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg   <= '0;
            row_reg   <= '0;
            prev1_reg <= '0;
            prev2_reg <= '0;
        end else begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            prev1_reg <= prev1_next;
            prev2_reg <= prev2_next;
        end
    end

    // ---------------- horizontal stage ----------------
    logic       st_e1_reg, st_e2_reg;
    logic       st_end_reg, st_last_reg;
    logic [7:0] st_v_reg, st_l1_reg, st_m1_reg, st_l2_reg;
    logic [1:0] st_n;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_e1_reg <= 1'b0;
            st_e2_reg <= 1'b0;
        end else begin
            st_e1_reg <= eff && emit1;
            st_e2_reg <= eff && emit2;
        end
    end

    always_ff @(posedge aclk) begin
        st_end_reg  <= end_row;
        st_last_reg <= last_row;
        st_v_reg    <= vert;
        st_m1_reg   <= prev1_reg;
        // left edge column replicates itself
        st_l1_reg   <= (col_reg == CW'(1)) ? prev1_reg : prev2_reg;
        // single column row: left neighbor is the column itself
        st_l2_reg   <= (col_reg == '0) ? vert : prev1_reg;
    end

    assign st_n = {1'b0, st_e1_reg} + {1'b0, st_e2_reg};

    result_t res1, res2;
    push_t   push;

    always_comb begin
        res1.pixel     = tap121(st_l1_reg, st_m1_reg, st_v_reg);
        res1.row_end   = st_end_reg && !st_e2_reg;
        res1.frame_end = st_end_reg && !st_e2_reg && st_last_reg;
        res2.pixel     = tap121(st_l2_reg, st_v_reg, st_v_reg);
        res2.row_end   = st_end_reg;
        res2.frame_end = st_end_reg && st_last_reg;
        push.cnt = st_n;
        push.r0  = st_e1_reg ? res1 : res2;
        push.r1  = res2;
    end

    // ---------------- result queue ----------------
    result_t                head;
    logic [OFIFO_CNT_W-1:0] q_count;

    b3lp_ofifo u_ofifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .pop     (m_tvalid && m_tready),
        .head    (head),
        .count   (q_count)
    );

    // room for the pending stage plus two more results
    assign s_tready = ({1'b0, q_count} + (OFIFO_CNT_W + 1)'(st_n))
                      <= (OFIFO_CNT_W + 1)'(OFIFO_DEPTH - 2);

    assign m_tvalid   = q_count != '0;
    assign m_tdata    = head.pixel;
    assign m_tlast    = head.row_end;
    assign m_tuser[0] = head.frame_end;

endmodule

/* sv/b3lp_chk.sv */
// ----------------------------------------------------------------------------
// b3lp_chk
// Port-level checks on the result channel, bound to the core.
// ----------------------------------------------------------------------------
`include "binomial_3x3_lowpass_core_macros.svh"

module b3lp_chk (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic [0:0] m_tuser
);

    property p_out_hold;
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
                                  && $stable(m_tlast) && $stable(m_tuser);
    endproperty

    // a stalled result holds
    `B3LP_ASSERT(a_out_hold, aclk, aresetn, p_out_hold)

    // frame end always closes a row
    `B3LP_ASSERT(a_frame_end_row, aclk, aresetn, m_tvalid && m_tuser[0] |-> m_tlast)

    // reset empties the result queue
    `B3LP_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid)

endmodule

bind binomial_3x3_lowpass_core b3lp_chk u_b3lp_chk (.*);
